// ===== rtl/irpd_pkg.sv =====
// Shared types and constants of the IR pulse-distance frame transmitter.
package irpd_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 10;
    localparam int SPACE_W  = 10;
    localparam int LEAD_W   = 12;
    localparam int TICK_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 12;

    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SEND  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MARK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD  = 2'd2;

    localparam logic [MARK_W-1:0]  MARK_RST  = 10'd35;
    localparam logic [SPACE_W-1:0] SPACE_RST = 10'd35;
    localparam logic [LEAD_W-1:0]  LEAD_RST  = 12'd385;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEAD,
        PH_MARK,
        PH_SPACE
    } phase_t;

    typedef enum logic [1:0] {
        SEG_START,
        SEG_LEN,
        SEG_DATA,
        SEG_END
    } seg_t;

    // controller -> datapath
    typedef struct packed {
        logic                res_valid;
        logic [STATUS_W-1:0] status;
        logic                frame_done;
        logic                mark_next;
        logic                busy_next;
        logic                seg_len;
        logic                seg_data;
        logic                tc_inc;
        logic                tc_clear;
        logic                spaces_load;
        logic                spaces_dec;
        logic                spaces_clear;
        logic                bit_inc;
        logic                bit_clear;
        logic                byte_inc;
        logic                byte_clear;
        logic                buf_write;
        logic                count_clear;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic lead_hit;
        logic lead_zero;
        logic mark_hit;
        logic space_hit;
        logic space_last;
        logic bit_last;
        logic len_zero;
        logic last_byte;
        logic buf_full;
    } dp_stat_t;

endpackage

// ===== rtl/irpd_ctrl.sv =====
// Frame sequencing state machine: phase, segment and item decode.
module irpd_ctrl
    import irpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [OPCODE_W-1:0] opcode,
    input  dp_stat_t            stat,
    output ctl_cmd_t            cmd
);

    phase_t phase_reg, phase_next;
    seg_t   seg_reg, seg_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            seg_reg   <= SEG_START;
        end
        else
        begin
            phase_reg <= phase_next;
            seg_reg   <= seg_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        seg_next   = seg_reg;
        cmd        = '0;
        cmd.res_valid = start;
        cmd.status    = ST_OK;

        if (start)
        begin
            unique case (opcode)
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        cmd.tc_inc = 1'b1;
                    end
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                        end
                        PH_LEAD:
                        begin
                            if (stat.lead_hit)
                            begin
                                phase_next   = PH_MARK;
                                cmd.tc_clear = 1'b1;
                            end
                        end
                        PH_MARK:
                        begin
                            if (stat.mark_hit)
                            begin
                                phase_next      = PH_SPACE;
                                cmd.tc_clear    = 1'b1;
                                cmd.spaces_load = 1'b1;
                            end
                        end
                        PH_SPACE:
                        begin
                            if (stat.space_hit)
                            begin
                                cmd.tc_clear   = 1'b1;
                                cmd.spaces_dec = 1'b1;
                                if (stat.space_last)
                                begin
                                    // last space unit of this bit: step to the next bit
                                    phase_next = PH_MARK;
                                    unique case (seg_reg)
                                        SEG_START:
                                        begin
                                            seg_next      = SEG_LEN;
                                            cmd.bit_clear = 1'b1;
                                        end
                                        SEG_LEN:
                                        begin
                                            if (!stat.bit_last)
                                            begin
                                                cmd.bit_inc = 1'b1;
                                            end
                                            else if (stat.len_zero)
                                            begin
                                                seg_next = SEG_END;
                                            end
                                            else
                                            begin
                                                seg_next       = SEG_DATA;
                                                cmd.byte_clear = 1'b1;
                                                cmd.bit_clear  = 1'b1;
                                            end
                                        end
                                        SEG_DATA:
                                        begin
                                            if (!stat.bit_last)
                                            begin
                                                cmd.bit_inc = 1'b1;
                                            end
                                            else
                                            begin
                                                cmd.bit_clear = 1'b1;
                                                if (stat.last_byte)
                                                begin
                                                    seg_next = SEG_END;
                                                end
                                                else
                                                begin
                                                    cmd.byte_inc = 1'b1;
                                                end
                                            end
                                        end
                                        SEG_END:
                                        begin
                                            phase_next      = PH_IDLE;
                                            seg_next        = SEG_START;
                                            cmd.bit_clear   = 1'b1;
                                            cmd.byte_clear  = 1'b1;
                                            cmd.count_clear = 1'b1;
                                            cmd.frame_done  = 1'b1;
                                        end
                                        default:
                                        begin
                                        end
                                    endcase
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_WRITE:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        cmd.status = ST_BUSY;
                    end
                    else if (stat.buf_full)
                    begin
                        cmd.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.buf_write = 1'b1;
                    end
                end
                OP_SEND:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        cmd.status = ST_BUSY;
                    end
                    else
                    begin
                        seg_next         = SEG_START;
                        cmd.bit_clear    = 1'b1;
                        cmd.byte_clear   = 1'b1;
                        cmd.spaces_clear = 1'b1;
                        cmd.tc_clear     = 1'b1;
                        // zero lead gap: mark starts right away
                        phase_next = stat.lead_zero ? PH_MARK : PH_LEAD;
                    end
                end
                default:
                begin
                end
            endcase
        end

        cmd.mark_next = (phase_next == PH_MARK);
        cmd.busy_next = (phase_next != PH_IDLE);
        cmd.seg_len   = (seg_reg == SEG_LEN);
        cmd.seg_data  = (seg_reg == SEG_DATA);
    end

endmodule

// ===== rtl/irpd_datapath.sv =====
// Datapath: config registers, tick/bit/byte counters, payload buffer, result registers.
module irpd_datapath
    import irpd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [7:0]           data_byte,
    input  ctl_cmd_t             cmd,
    output dp_stat_t             stat,
    output logic                 valid,
    output logic                 ir_level,
    output logic                 busy_res,
    output logic                 frame_done,
    output logic [STATUS_W-1:0]  status
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    // length field is 8 bits wide
    localparam logic [7:0] CAPACITY = (BUFFER_DEPTH > 255) ? 8'd255 : 8'(BUFFER_DEPTH);

    logic [MARK_W-1:0]   mark_reg;
    logic [SPACE_W-1:0]  space_reg;
    logic [LEAD_W-1:0]   lead_reg;

    logic [TICK_W-1:0]   tick_reg, tick_next, tick_inc;
    logic [1:0]          spaces_reg, spaces_next;
    logic [2:0]          bit_reg, bit_next;
    logic [7:0]          byte_reg, byte_next;
    logic [7:0]          count_reg, count_next;

    logic [7:0]          buf_mem [BUFFER_DEPTH];
    logic [7:0]          rd_reg;

    logic [MARK_W-1:0]   mark_eff;
    logic [SPACE_W-1:0]  space_eff;
    logic [8:0]          byte_plus;
    logic                cur_bit;

    logic                valid_reg;
    logic                level_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= MARK_RST;
            space_reg <= SPACE_RST;
            lead_reg  <= LEAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MARK:  mark_reg  <= cfg_wdata[MARK_W-1:0];
                REG_SPACE: space_reg <= cfg_wdata[SPACE_W-1:0];
                REG_LEAD:  lead_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign tick_inc  = tick_reg + TICK_W'(1);
    assign mark_eff  = (mark_reg == '0) ? MARK_W'(1) : mark_reg;
    assign space_eff = (space_reg == '0) ? SPACE_W'(1) : space_reg;
    assign byte_plus = {1'b0, byte_reg} + 9'd1;

    always_comb
    begin
        if (cmd.seg_len)
        begin
            cur_bit = count_reg[~bit_reg];
        end
        else if (cmd.seg_data)
        begin
            cur_bit = rd_reg[~bit_reg];
        end
        else
        begin
            cur_bit = 1'b1;
        end
    end

    always_comb
    begin
        stat.lead_hit   = (tick_inc >= lead_reg);
        stat.lead_zero  = (lead_reg == '0);
        stat.mark_hit   = (tick_inc >= TICK_W'(mark_eff));
        stat.space_hit  = (tick_inc >= TICK_W'(space_eff));
        stat.space_last = (spaces_reg == 2'd1);
        stat.bit_last   = (bit_reg == 3'd7);
        stat.len_zero   = (count_reg == '0);
        stat.last_byte  = (byte_plus >= {1'b0, count_reg});
        stat.buf_full   = (count_reg >= CAPACITY);
    end

    always_comb
    begin
        tick_next = tick_reg;
        if (cmd.tc_clear)
        begin
            tick_next = '0;
        end
        else if (cmd.tc_inc)
        begin
            tick_next = tick_inc;
        end

        spaces_next = spaces_reg;
        if (cmd.spaces_clear)
        begin
            spaces_next = '0;
        end
        else if (cmd.spaces_load)
        begin
            // a one gets one space unit, a zero gets two
            spaces_next = cur_bit ? 2'd1 : 2'd2;
        end
        else if (cmd.spaces_dec)
        begin
            spaces_next = spaces_reg - 2'd1;
        end

        bit_next = bit_reg;
        if (cmd.bit_clear)
        begin
            bit_next = '0;
        end
        else if (cmd.bit_inc)
        begin
            bit_next = bit_reg + 3'd1;
        end

        byte_next = byte_reg;
        if (cmd.byte_clear)
        begin
            byte_next = '0;
        end
        else if (cmd.byte_inc)
        begin
            byte_next = byte_plus[7:0];
        end

        count_next = count_reg;
        if (cmd.count_clear)
        begin
            count_next = '0;
        end
        else if (cmd.buf_write)
        begin
            count_next = count_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg   <= '0;
            spaces_reg <= '0;
            bit_reg    <= '0;
            byte_reg   <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            tick_reg   <= tick_next;
            spaces_reg <= spaces_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            count_reg  <= count_next;
            valid_reg  <= cmd.res_valid;
        end
    end

    // Read address follows the next byte index so data is ready as soon as
    // the index moves.
    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
        begin
            buf_mem[count_reg[AW-1:0]] <= data_byte;
        end
        rd_reg <= buf_mem[byte_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        level_reg  <= cmd.mark_next & ~tick_next[0];
        busy_reg   <= cmd.busy_next;
        done_reg   <= cmd.frame_done;
        status_reg <= cmd.status;
    end

    assign valid      = valid_reg;
    assign ir_level   = level_reg;
    assign busy_res   = busy_reg;
    assign frame_done = done_reg;
    assign status     = status_reg;

endmodule

// ===== rtl/ir_pulse_distance_frame_tx_unit.sv =====
// Top level of the IR pulse-distance frame transmitter.
// One item is taken per clock: start is sampled every cycle and busy stays
// low, since the controller and counters settle each tick, write or send
// without stalling. The result beat appears on the cycle after the
// item, marked by valid for exactly one cycle; there is no backpressure, so
// the receiver must take every beat. ir_level is the emitter drive after the
// item; busy_res is high while a frame is in flight. Configuration writes
// take effect at the write edge; a change during a frame applies from the
// next tick, and an interval already past the new value ends on that tick.
// Payload bytes are held in a BUFFER_DEPTH x 8 buffer with a registered read.
module ir_pulse_distance_frame_tx_unit
    import irpd_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [7:0]           data_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic                 valid,
    output logic                 ir_level,
    output logic                 busy_res,
    output logic                 frame_done,
    output logic [STATUS_W-1:0]  status
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    assign busy = 1'b0;

    irpd_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd)
    );

    irpd_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .data_byte  (data_byte),
        .cmd        (cmd),
        .stat       (stat),
        .valid      (valid),
        .ir_level   (ir_level),
        .busy_res   (busy_res),
        .frame_done (frame_done),
        .status     (status)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the IR pulse-distance frame transmitter.
`timescale 1ns / 1ps

module tb_top
    import irpd_pkg::*;
();

    localparam int          FRAME_CAP   = (BUFFER_DEPTH_DEF > 255) ? 255 : BUFFER_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 200_000;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [7:0]          data;
    } tx_item_t;

    typedef struct packed {
        logic                ir_level;
        logic                busy_res;
        logic                frame_done;
        logic [STATUS_W-1:0] status;
    } ir_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [OPCODE_W-1:0]  opcode = OP_TICK;
    logic [7:0]           data_byte = 8'h00;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MARK;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 valid;
    logic                 ir_level;
    logic                 busy_res;
    logic                 frame_done;
    logic [STATUS_W-1:0]  status;

    ir_pulse_distance_frame_tx_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .valid      (valid),
        .ir_level   (ir_level),
        .busy_res   (busy_res),
        .frame_done (frame_done),
        .status     (status)
    );

    tx_item_t    tx_items[$];
    ir_beat_t    expected_beats[$];
    tx_item_t    drv_item;
    ir_beat_t    exp_beat;
    int          burst_left = 0;
    int          gap_left = 0;
    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          beats_checked = 0;
    int          frames_seen = 0;
    int          busy_rejects = 0;
    int          full_rejects = 0;

    // shadow of the transmitter
    logic [MARK_W-1:0]  cfg_mark = MARK_RST;
    logic [SPACE_W-1:0] cfg_space = SPACE_RST;
    logic [LEAD_W-1:0]  cfg_lead = LEAD_RST;
    logic [7:0]         m_buf [BUFFER_DEPTH_DEF];
    logic [7:0]         m_count = '0;
    phase_t             m_phase = PH_IDLE;
    seg_t               m_seg = SEG_START;
    logic [TICK_W-1:0]  m_tick = '0;
    logic [2:0]         m_bitpos = '0;
    logic [7:0]         m_byteidx = '0;
    logic [1:0]         m_spaces = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // value of the bit whose mark just ended
    function automatic logic frame_bit();
        logic [2:0] sh;
        sh = 3'd7 - m_bitpos;
        if (m_seg == SEG_LEN)
            return m_count[sh];
        if (m_seg == SEG_DATA)
            return m_buf[m_byteidx][sh];
        return 1'b1;
    endfunction

    task automatic predict_ir_beat(input logic [OPCODE_W-1:0] op,
                                   input logic [7:0] dbyte);
        ir_beat_t            e;
        logic                done;
        logic [STATUS_W-1:0] st;
        logic [MARK_W-1:0]   mk;
        logic [SPACE_W-1:0]  sp;
        done = 1'b0;
        st   = ST_OK;
        mk   = (cfg_mark == 0) ? MARK_W'(1) : cfg_mark;
        sp   = (cfg_space == 0) ? SPACE_W'(1) : cfg_space;
        case (op)
            OP_TICK:
            begin
                if (m_phase != PH_IDLE)
                begin
                    m_tick = m_tick + 1'b1;
                    case (m_phase)
                        PH_LEAD:
                        begin
                            if (m_tick >= cfg_lead)
                            begin
                                m_phase = PH_MARK;
                                m_tick  = '0;
                            end
                        end
                        PH_MARK:
                        begin
                            if (m_tick >= mk)
                            begin
                                m_spaces = frame_bit() ? 2'd1 : 2'd2;
                                m_phase  = PH_SPACE;
                                m_tick   = '0;
                            end
                        end
                        default:
                        begin
                            if (m_tick >= sp)
                            begin
                                m_tick   = '0;
                                m_spaces = m_spaces - 1'b1;
                                if (m_spaces == 0)
                                begin
                                    if (m_seg == SEG_END)
                                    begin
                                        m_phase   = PH_IDLE;
                                        m_seg     = SEG_START;
                                        m_bitpos  = '0;
                                        m_byteidx = '0;
                                        m_count   = '0;
                                        done      = 1'b1;
                                    end
                                    else
                                    begin
                                        case (m_seg)
                                            SEG_START:
                                            begin
                                                m_seg    = SEG_LEN;
                                                m_bitpos = '0;
                                            end
                                            SEG_LEN:
                                            begin
                                                if (m_bitpos != 3'd7)
                                                    m_bitpos = m_bitpos + 1'b1;
                                                else if (m_count == 0)
                                                    m_seg = SEG_END;
                                                else
                                                begin
                                                    m_seg     = SEG_DATA;
                                                    m_byteidx = '0;
                                                    m_bitpos  = '0;
                                                end
                                            end
                                            default:
                                            begin
                                                if (m_bitpos != 3'd7)
                                                    m_bitpos = m_bitpos + 1'b1;
                                                else
                                                begin
                                                    m_bitpos = '0;
                                                    if (int'(m_byteidx) + 1 >= int'(m_count))
                                                        m_seg = SEG_END;
                                                    else
                                                        m_byteidx = m_byteidx + 1'b1;
                                                end
                                            end
                                        endcase
                                        m_phase = PH_MARK;
                                        m_tick  = '0;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            OP_WRITE:
            begin
                if (m_phase != PH_IDLE)
                    st = ST_BUSY;
                else if (int'(m_count) >= FRAME_CAP)
                    st = ST_FULL;
                else
                begin
                    m_buf[m_count] = dbyte;
                    m_count = m_count + 1'b1;
                end
            end
            OP_SEND:
            begin
                if (m_phase != PH_IDLE)
                    st = ST_BUSY;
                else
                begin
                    m_seg     = SEG_START;
                    m_bitpos  = '0;
                    m_byteidx = '0;
                    m_spaces  = '0;
                    m_tick    = '0;
                    // zero lead gap: the start mark begins on the send itself
                    m_phase   = (cfg_lead == 0) ? PH_MARK : PH_LEAD;
                end
            end
            default:
            begin
            end
        endcase
        e.ir_level   = (m_phase == PH_MARK) && !m_tick[0];
        e.busy_res   = (m_phase != PH_IDLE);
        e.frame_done = done;
        e.status     = st;
        expected_beats.push_back(e);
    endtask

    // command driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            opcode     <= OP_TICK;
            data_byte  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!(start && busy))
        begin
            if (start)
                predict_ir_beat(opcode, data_byte);
            if (gap_left != 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (tx_items.size() != 0)
            begin
                drv_item = tx_items.pop_front();
                start     <= 1'b1;
                opcode    <= drv_item.op;
                data_byte <= drv_item.data;
                if (burst_left == 0)
                begin
                    burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                               : $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_beats.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result beat at cycle %0d", cycle_count);
                mismatches++;
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                if (ir_level !== exp_beat.ir_level || busy_res !== exp_beat.busy_res ||
                    frame_done !== exp_beat.frame_done || status !== exp_beat.status)
                begin
                    if (mismatches < 10)
                    begin
                        $display("mismatch at cycle %0d: exp lvl=%0b busy=%0b done=%0b st=%0d",
                                 cycle_count, exp_beat.ir_level, exp_beat.busy_res,
                                 exp_beat.frame_done, exp_beat.status);
                        $display("    got lvl=%0b busy=%0b done=%0b st=%0d",
                                 ir_level, busy_res, frame_done, status);
                    end
                    mismatches++;
                end
                beats_checked++;
                if (exp_beat.frame_done)
                    frames_seen++;
                if (exp_beat.status == ST_BUSY)
                    busy_rejects++;
                if (exp_beat.status == ST_FULL)
                    full_rejects++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [7:0] data);
        tx_item_t it;
        it.op   = op;
        it.data = data;
        tx_items.push_back(it);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tx_items.size() != 0 || start || expected_beats.size() != 0);
    endtask

    // tick until the shadow says the frame is over, then let the block settle
    task automatic finish_frame();
        wait_drained();
        while (m_phase != PH_IDLE)
        begin
            repeat (16) push_item(OP_TICK, 8'($urandom));
            wait_drained();
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic program_timing(input logic [MARK_W-1:0] mk, input logic [SPACE_W-1:0] sp,
                                  input logic [LEAD_W-1:0] ld);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MARK;
        cfg_wdata <= CFG_W'(mk);
        @(posedge clk);
        cfg_index <= REG_SPACE;
        cfg_wdata <= CFG_W'(sp);
        @(posedge clk);
        cfg_index <= REG_LEAD;
        cfg_wdata <= CFG_W'(ld);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_mark  = mk;
        cfg_space = sp;
        cfg_lead  = ld;
        @(negedge clk);
    endtask

    // well-formed load/send/tick sequences with stray commands mixed in
    task automatic queue_random_traffic(input int target);
        int n;
        int k;
        int est;
        int nt;
        bit paused;
        n = 0;
        paused = 1'b0;
        while (n < target)
        begin
            if (!paused && n >= target / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 6)
            begin
                push_item(OPCODE_W'($urandom_range(0, 3)), 8'($urandom));
                n++;
            end
            else
            begin
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
                repeat (k) push_item(OP_WRITE, 8'($urandom));
                push_item(OP_SEND, 8'($urandom));
                est = int'(cfg_lead) + (10 + 8 * k) *
                      ((cfg_mark == 0 ? 1 : int'(cfg_mark)) +
                       2 * (cfg_space == 0 ? 1 : int'(cfg_space)));
                // sometimes cut short so the next load hits a busy transmitter
                nt = est * $urandom_range(70, 130) / 100 + 1;
                for (int i = 0; i < nt; i++)
                begin
                    if ($urandom_range(0, 99) < 3)
                        push_item(OPCODE_W'($urandom_range(1, 3)), 8'($urandom));
                    push_item(OP_TICK, 8'($urandom));
                end
                n += k + 1 + nt;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset timing: idle tick, no-op, a three-byte frame, commands while busy
        push_item(OP_TICK, 8'h00);
        push_item(2'd3, 8'hFF);
        push_item(OP_WRITE, 8'h00);
        push_item(OP_WRITE, 8'hFF);
        push_item(OP_WRITE, 8'h5A);
        push_item(OP_SEND, 8'h00);
        push_item(OP_WRITE, 8'h11);
        push_item(OP_SEND, 8'hFF);
        push_item(2'd3, 8'h00);
        // lead gap, start mark and its space at reset timing
        repeat (460) push_item(OP_TICK, 8'($urandom));
        wait_drained();
        // shorter timing mid-frame: an interval already past it ends on the next tick
        program_timing(10'd1, 10'd1, 12'd1);
        finish_frame();

        // zero lead gap, empty frame then one byte
        program_timing(10'd1, 10'd1, 12'd0);
        push_item(OP_SEND, 8'h00);
        repeat (3) push_item(OP_TICK, 8'h00);
        push_item(OP_SEND, 8'h00);
        finish_frame();
        push_item(OP_WRITE, 8'h80);
        push_item(OP_SEND, 8'h00);
        finish_frame();

        // zero mark and space registers behave as one tick
        program_timing(10'd0, 10'd0, 12'd1);
        push_item(OP_WRITE, 8'h01);
        push_item(OP_SEND, 8'h00);
        finish_frame();

        // widest timing values, then a zero lead gap while the lead runs
        program_timing(10'd1023, 10'd1023, 12'd4095);
        push_item(OP_SEND, 8'h00);
        repeat (32) push_item(OP_TICK, 8'($urandom));
        wait_drained();
        program_timing(10'd2, 10'd1, 12'd0);
        finish_frame();

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 3)
                program_timing(10'($urandom_range(0, 2)), 10'($urandom_range(0, 2)),
                               12'($urandom_range(0, 4)));
            else
                program_timing(10'($urandom_range(1, 3)), 10'($urandom_range(1, 2)),
                               12'($urandom_range(0, 8)));
            queue_random_traffic(130);
            finish_frame();
        end

        // fill the buffer to capacity and overflow it
        repeat (FRAME_CAP) push_item(OP_WRITE, 8'($urandom));
        push_item(OP_WRITE, 8'hC3);
        push_item(OP_WRITE, 8'h3C);
        push_item(OP_TICK, 8'h00);

        wait_drained();
        repeat (16) @(posedge clk);
        $display("checked %0d result beats: %0d frames completed, %0d busy rejects, %0d full rejects",
                 beats_checked, frames_seen, busy_rejects, full_rejects);
        $display("timing settings included zero, reset and maximum values; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/irpd_pkg.sv
rtl/irpd_ctrl.sv
rtl/irpd_datapath.sv
rtl/ir_pulse_distance_frame_tx_unit.sv
dv/tb_top.sv
